// File: design/bfiq_pkg.sv
// Package for the Bloom filter block: widths, hash constants, register
// indexes, command codes and the memory control struct.
// No dependencies.
`timescale 1ns / 1ps
package bfiq_pkg;

  // Default sizing of the filter bit array.
  localparam int unsigned DEF_MAX_FILTER_BITS = 65536;

  // Fixed key and hash limits.
  localparam int unsigned MAX_KEY_BYTES = 8;
  localparam int unsigned MAX_HASHES    = 16;

  // Field and register widths.
  localparam int unsigned KEY_W      = 64;
  localparam int unsigned LEN_W      = 4;
  localparam int unsigned REG_W      = 17;
  localparam int unsigned HC_W       = 5;
  localparam int unsigned CFG_AW     = 2;
  localparam int unsigned IN_DATA_W  = 72;
  localparam int unsigned OUT_DATA_W = 24;

  // The bit array is stored as rows of 32 bits.
  localparam int unsigned ROW_W  = 32;
  localparam int unsigned ROW_SH = 5;

  // Murmur constants.
  localparam logic [31:0] MIX_MUL   = 32'h5bd1e995;
  localparam logic [31:0] SEED_STEP = 32'd836091947;

  // Capacity saturates at this count.
  localparam logic [REG_W-1:0] CAP_LIMIT = 17'd65536;

  // Configuration register indexes.
  localparam logic [CFG_AW-1:0] CFG_BIT_COUNT  = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_HASH_COUNT = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_ENTRY_CAP  = 2'd2;

  // Command codes.
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  // Control strobes from the sequencer to the bit array.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

endpackage

// File: design/bfiq_hash.sv
// Iterative MurmurHash2A unit built around one shared 32x32 multiplier.
// Depends on bfiq_pkg.
`timescale 1ns / 1ps
module bfiq_hash (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [bfiq_pkg::KEY_W-1:0] key,
  input  logic [bfiq_pkg::LEN_W-1:0] len,
  input  logic [31:0]                seed,
  output logic                       done,
  output logic [31:0]                hash
);
  import bfiq_pkg::*;

  // Phases of one mix step and of the final avalanche.
  localparam logic [2:0] PH_KMUL1 = 3'd0;
  localparam logic [2:0] PH_KMUL2 = 3'd1;
  localparam logic [2:0] PH_HMUL  = 3'd2;
  localparam logic [2:0] PH_XOR   = 3'd3;
  localparam logic [2:0] PH_FMUL  = 3'd4;
  localparam logic [2:0] PH_FOUT  = 3'd5;

  logic        busy_r;
  logic        done_r;
  logic [2:0]  ph_r;
  logic [1:0]  m_r;
  logic [31:0] h_r;
  logic [31:0] k_r;
  logic [31:0] p_r;
  logic [31:0] hash_r;

  logic [1:0]  nblk;
  logic [1:0]  rest;
  logic [63:0] shifted;
  logic [31:0] tail_mask;
  logic [31:0] word;
  logic [31:0] mul_in;
  logic [31:0] prod;
  logic        last_mix;

  // Whole 4-byte blocks, then the tail bytes after them.
  assign nblk    = len[3:2];
  assign rest    = len[1:0];
  assign shifted = key >> {nblk, 5'd0};

  always_comb begin
    case (rest)
      2'd0:    tail_mask = 32'h0000_0000;
      2'd1:    tail_mask = 32'h0000_00FF;
      2'd2:    tail_mask = 32'h0000_FFFF;
      default: tail_mask = 32'h00FF_FFFF;
    endcase
  end

  // Word mixed in step m: key blocks, then tail, then the length.
  always_comb begin
    if (m_r < nblk) begin
      word = m_r[0] ? key[63:32] : key[31:0];
    end else if (m_r == nblk) begin
      word = shifted[31:0] & tail_mask;
    end else begin
      word = {28'd0, len};
    end
  end

  assign last_mix = (m_r == (nblk + 2'd1));

  // Operand select for the shared multiplier.
  always_comb begin
    case (ph_r)
      PH_KMUL1: mul_in = word;
      PH_KMUL2: mul_in = p_r ^ (p_r >> 24);
      PH_HMUL:  mul_in = h_r;
      PH_FMUL:  mul_in = h_r ^ (h_r >> 13);
      default:  mul_in = word;
    endcase
  end

  // Only the low 32 bits of the product are kept.
  assign prod = mul_in * MIX_MUL;

  // Control of the step sequence.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      ph_r   <= PH_KMUL1;
      m_r    <= 2'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        ph_r   <= PH_KMUL1;
        m_r    <= 2'd0;
      end else if (busy_r) begin
        case (ph_r)
          PH_KMUL1: ph_r <= PH_KMUL2;
          PH_KMUL2: ph_r <= PH_HMUL;
          PH_HMUL:  ph_r <= PH_XOR;
          PH_XOR: begin
            if (last_mix) begin
              ph_r <= PH_FMUL;
            end else begin
              m_r  <= m_r + 2'd1;
              ph_r <= PH_KMUL1;
            end
          end
          PH_FMUL:  ph_r <= PH_FOUT;
          default: begin
            busy_r <= 1'b0;
            done_r <= 1'b1;
          end
        endcase
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (start) begin
      h_r <= seed;
    end else if (busy_r) begin
      case (ph_r)
        PH_KMUL1: p_r <= prod;
        PH_KMUL2: p_r <= prod;
        PH_HMUL: begin
          k_r <= p_r;
          p_r <= prod;
        end
        PH_XOR:   h_r <= p_r ^ k_r;
        PH_FMUL:  p_r <= prod;
        default:  hash_r <= p_r ^ (p_r >> 15);
      endcase
    end
  end

  assign done = done_r;
  assign hash = hash_r;

endmodule

// File: design/bfiq_mod.sv
// Iterative remainder unit: 32-bit value modulo a 17-bit bit count,
// four restoring steps per cycle. Depends on bfiq_pkg.
`timescale 1ns / 1ps
module bfiq_mod (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [31:0]                num,
  input  logic [bfiq_pkg::REG_W-1:0] den,
  output logic                       done,
  output logic [bfiq_pkg::REG_W-1:0] rem
);
  import bfiq_pkg::*;

  localparam int unsigned STEPS = 4;

  logic             busy_r;
  logic             done_r;
  logic [2:0]       cnt_r;
  logic [31:0]      q_r;
  logic [REG_W:0]   r_r;
  logic [REG_W:0]   r_step;

  // Four dependent compare-subtract steps on the partial remainder.
  always_comb begin
    logic [REG_W:0] t;
    t = r_r;
    for (int j = 0; j < STEPS; j++) begin
      t = {t[REG_W-1:0], q_r[31-j]};
      if (t >= {1'b0, den}) begin
        t = t - {1'b0, den};
      end
    end
    r_step = t;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 3'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 3'd0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 3'd1;
        if (cnt_r == 3'd7) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Dividend shifts out four bits a cycle.
  always_ff @(posedge clk) begin
    if (start) begin
      q_r <= num;
      r_r <= '0;
    end else if (busy_r) begin
      q_r <= q_r << STEPS;
      r_r <= r_step;
    end
  end

  assign done = done_r;
  assign rem  = r_r[REG_W-1:0];

endmodule

// File: design/bfiq_mem.sv
// Filter bit array stored as 32-bit rows, with a clearing pass after reset.
// Depends on bfiq_pkg.
`timescale 1ns / 1ps
module bfiq_mem #(
  parameter int unsigned ROWS = 2048,
  parameter int unsigned RAW  = 11
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  bfiq_pkg::mem_ctl_t         ctl,
  input  logic [RAW-1:0]             rd_addr,
  input  logic [RAW-1:0]             wr_addr,
  input  logic [bfiq_pkg::ROW_W-1:0] wr_data,
  output logic [bfiq_pkg::ROW_W-1:0] rd_data,
  output logic                       clearing
);
  import bfiq_pkg::*;

  localparam logic [RAW-1:0] LAST_ROW = RAW'(ROWS - 1);

  logic [ROW_W-1:0] mem [ROWS];
  logic [ROW_W-1:0] rd_data_r;
  logic             clr_r;
  logic [RAW-1:0]   clr_addr_r;

  // Clearing sweep, one row per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_r) begin
      clr_addr_r <= clr_addr_r + RAW'(1);
      if (clr_addr_r == LAST_ROW) begin
        clr_r <= 1'b0;
      end
    end
  end

  // Single write port shared by the sweep and the sequencer.
  always_ff @(posedge clk) begin
    if (clr_r) begin
      mem[clr_addr_r] <= '0;
    end else if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data  = rd_data_r;
  assign clearing = clr_r;

endmodule

// File: design/bloom_filter_insert_query.sv
// Bloom filter top level: sequencer over the shared hash, remainder and
// bit-array units. Depends on bfiq_pkg, bfiq_hash, bfiq_mod and bfiq_mem.
//
//   Channel   Direction  Item contents
//   in_       slave      tuser: command; tdata: key_bytes[63:0], key_length[67:64]
//   out_      master     tdata: hit[0], full_res[1], entry_count[18:2]
//   cfg_      write      cfg_addr 0 bit_count, 1 hash_count, 2 entry_capacity
//
// Each hash pass runs m = 2..4 mixes, by key length, on the one shared
// multiplier, then the four-bit-per-cycle remainder unit. An item takes
// hash_count such passes; a refused insert takes none and goes straight
// to its result. A query stops at its first clear bit.
// After reset the bit array is swept clear, one 32-bit row per cycle
// (ceil(MAX_FILTER_BITS/32) rows, 2048 by default); no item is taken then.
// One item is in work at a time; a new item is taken once the result
// register is empty or being emptied.
`timescale 1ns / 1ps
module bloom_filter_insert_query #(
  parameter int unsigned MAX_FILTER_BITS = bfiq_pkg::DEF_MAX_FILTER_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Input items
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [bfiq_pkg::IN_DATA_W-1:0]  in_tdata,   // key_bytes, key_length
  input  logic                            in_tuser,   // command
  // Result items
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [bfiq_pkg::OUT_DATA_W-1:0] out_tdata,  // hit, full_res, entry_count
  // Configuration writes
  input  logic                            cfg_we,
  input  logic [bfiq_pkg::CFG_AW-1:0]     cfg_addr,
  input  logic [bfiq_pkg::REG_W-1:0]      cfg_wdata
);
  import bfiq_pkg::*;

  localparam int unsigned ROWS = (MAX_FILTER_BITS + ROW_W - 1) / ROW_W;
  localparam int unsigned RAW  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam logic [REG_W-1:0] NBITS_MAX =
    (MAX_FILTER_BITS > 131071) ? 17'h1FFFF : REG_W'(MAX_FILTER_BITS);

  // Sequencer states.
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_HSTART = 3'd1;
  localparam logic [2:0] S_HASH   = 3'd2;
  localparam logic [2:0] S_MOD    = 3'd3;
  localparam logic [2:0] S_RD     = 3'd4;
  localparam logic [2:0] S_UPD    = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [REG_W-1:0] bit_count_r;
  logic [HC_W-1:0]  hash_count_r;
  logic [REG_W-1:0] cap_r;

  logic [2:0]       state_r;
  logic             cmd_r;
  logic [KEY_W-1:0] key_r;
  logic [LEN_W-1:0] len_r;
  logic [31:0]      seed_r;
  logic [HC_W-1:0]  hidx_r;
  logic             hit_r;
  logic             full_r;
  logic [RAW-1:0]   row_r;
  logic [4:0]       bsel_r;
  logic [REG_W-1:0] count_r;
  logic [REG_W-1:0] count_nxt;

  logic             out_valid_r;
  logic             out_hit_r;
  logic             out_full_r;
  logic [REG_W-1:0] out_count_r;

  logic [REG_W-1:0] nbits_eff;
  logic [HC_W-1:0]  nhash_eff;
  logic [REG_W-1:0] cap_eff;
  logic [LEN_W-1:0] in_len_sat;
  logic             in_cmd;
  logic             accept;
  logic             refuse;
  logic             last_hash;
  logic             bit_set;

  logic             hash_start;
  logic             hash_done;
  logic [31:0]      hash_val;
  logic             mod_start;
  logic             mod_done;
  logic [REG_W-1:0] mod_rem;
  logic [31:0]      rem32;
  mem_ctl_t         mem_ctl;
  logic [ROW_W-1:0] mem_rd_data;
  logic [ROW_W-1:0] mem_wr_data;
  logic             mem_clearing;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_count_r  <= 17'd65536;
      hash_count_r <= 5'd4;
      cap_r        <= 17'd65536;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_BIT_COUNT:  bit_count_r  <= cfg_wdata;
        CFG_HASH_COUNT: hash_count_r <= cfg_wdata[HC_W-1:0];
        CFG_ENTRY_CAP:  cap_r        <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Settings as used: zero bit and hash counts become one, out-of-range values saturate.
  always_comb begin
    if (bit_count_r == '0) begin
      nbits_eff = 17'd1;
    end else if (32'(bit_count_r) > MAX_FILTER_BITS) begin
      nbits_eff = NBITS_MAX;
    end else begin
      nbits_eff = bit_count_r;
    end
    if (hash_count_r == '0) begin
      nhash_eff = 5'd1;
    end else if (32'(hash_count_r) > MAX_HASHES) begin
      nhash_eff = HC_W'(MAX_HASHES);
    end else begin
      nhash_eff = hash_count_r;
    end
    cap_eff = (cap_r > CAP_LIMIT) ? CAP_LIMIT : cap_r;
  end

  assign in_cmd     = in_tuser;
  assign in_len_sat = (32'(in_tdata[67:64]) > MAX_KEY_BYTES) ?
                      LEN_W'(MAX_KEY_BYTES) : in_tdata[67:64];
  assign in_tready  = (state_r == S_IDLE) && !mem_clearing &&
                      (!out_valid_r || out_tready);
  assign accept     = in_tvalid && in_tready;
  assign refuse     = (in_cmd == CMD_INSERT) && (count_r >= cap_eff);
  assign last_hash  = (hidx_r == (nhash_eff - 5'd1));
  assign bit_set    = mem_rd_data[bsel_r];
  assign count_nxt  = ((cmd_r == CMD_INSERT) && !full_r && hit_r) ?
                      count_r + 17'd1 : count_r;

  // Handshakes with the shared units.
  assign hash_start  = (state_r == S_HSTART);
  assign mod_start   = (state_r == S_HASH) && hash_done;
  assign rem32       = {15'd0, mod_rem};
  assign mem_ctl.rd_en = (state_r == S_MOD) && mod_done;
  assign mem_ctl.wr_en = (state_r == S_UPD) && (cmd_r == CMD_INSERT);
  assign mem_wr_data = mem_rd_data | (32'd1 << bsel_r);

  // Item sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            state_r <= refuse ? S_DONE : S_HSTART;
          end
        end
        S_HSTART: state_r <= S_HASH;
        S_HASH: begin
          if (hash_done) begin
            state_r <= S_MOD;
          end
        end
        S_MOD: begin
          if (mod_done) begin
            state_r <= S_RD;
          end
        end
        S_RD: state_r <= S_UPD;
        S_UPD: begin
          if ((cmd_r == CMD_QUERY && !bit_set) || last_hash) begin
            state_r <= S_DONE;
          end else begin
            state_r <= S_HSTART;
          end
        end
        S_DONE: begin
          count_r <= count_nxt;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Per-item working registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r  <= in_cmd;
      key_r  <= in_tdata[63:0];
      len_r  <= in_len_sat;
      seed_r <= '0;
      hidx_r <= '0;
      full_r <= refuse;
      hit_r  <= (in_cmd == CMD_QUERY) && !refuse;
    end else begin
      if (mem_ctl.rd_en) begin
        row_r  <= rem32[ROW_SH +: RAW];
        bsel_r <= rem32[4:0];
      end
      if (state_r == S_UPD) begin
        if (!bit_set) begin
          hit_r <= (cmd_r == CMD_INSERT);
        end
        hidx_r <= hidx_r + 5'd1;
        seed_r <= seed_r + SEED_STEP;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_DONE) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DONE) begin
      out_hit_r   <= hit_r;
      out_full_r  <= full_r;
      out_count_r <= count_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_count_r, out_full_r, out_hit_r};

  bfiq_hash u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .start (hash_start),
    .key   (key_r),
    .len   (len_r),
    .seed  (seed_r),
    .done  (hash_done),
    .hash  (hash_val)
  );

  bfiq_mod u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mod_start),
    .num   (hash_val),
    .den   (nbits_eff),
    .done  (mod_done),
    .rem   (mod_rem)
  );

  bfiq_mem #(
    .ROWS (ROWS),
    .RAW  (RAW)
  ) u_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (mem_ctl),
    .rd_addr  (rem32[ROW_SH +: RAW]),
    .wr_addr  (row_r),
    .wr_data  (mem_wr_data),
    .rd_data  (mem_rd_data),
    .clearing (mem_clearing)
  );

  // No item is taken while the clearing sweep runs.
  assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> !mem_clearing)
    else $error("item accepted during clearing sweep");

  // The entry count only ever steps up by one.
  assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (count_r != $past(count_r))) |->
      (count_r == $past(count_r) + 17'd1))
    else $error("entry count jumped");

  // A refused insert never reports newly set bits.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_full_r) |-> !out_hit_r)
    else $error("refused insert reports a hit");

  // Hash results only arrive while the sequencer waits for them.
  assert property (@(posedge clk) disable iff (!rst_n)
    hash_done |-> (state_r == S_HASH))
    else $error("hash finished outside its wait state");

endmodule
